>>> sv/assert_macros.svh
// Assertion macros used by the tangent-from-uv unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/ttuv_pkg.sv
// Widths, constants and shared types of the tangent-from-uv block.
package ttuv_pkg;

	localparam int POS_W  = 32;              // Q16.16 position
	localparam int TEX_W  = 16;              // Q4.12 texcoord
	localparam int DU_W   = TEX_W + 1;       // uv delta
	localparam int E_W    = POS_W + 1;       // position edge
	localparam int MB_W   = E_W + 1;         // multiplier b operand
	localparam int ACC_W  = DU_W + MB_W;     // product / accumulator
	localparam int DET_W  = 35;              // determinant, Q11.24
	localparam int QUO_W  = 32;              // tangent component
	localparam int SCALE_SH = 12;            // numerator pre-scale
	localparam int LO_W   = QUO_W - SCALE_SH;
	localparam int HI_W   = ACC_W - LO_W;
	localparam int DIG_N  = QUO_W / 2;       // radix-4 digits

	localparam logic signed [DU_W-1:0] UV_ONE = DU_W'(4096);
	localparam logic [QUO_W-1:0] SAT_MAX = {1'b0, {(QUO_W-1){1'b1}}};
	localparam logic [QUO_W-1:0] SAT_MIN = {1'b1, {(QUO_W-1){1'b0}}};

	typedef struct packed {
		logic             done;
		logic             clip;
		logic [QUO_W-1:0] quo;
	} ttuv_div_stat_t;

endpackage

>>> sv/triangle_tangent_from_uv_unit.sv
// Per-triangle tangent from uv gradients; one result on every third vertex transfer.
// Vertices 0 and 1 of a triangle are taken in one cycle each and give no result.
// Third vertex: its result comes from eight passes through one shared multiplier and
// three 16-step radix-4 divisions (only the two det products when singular).
// Input stalls while a triangle is being worked, until its result is in the output register.
// arst_n clears sequencer, vertex slot and output valid; held vertices are not reset.
`include "assert_macros.svh"

module triangle_tangent_from_uv_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// vertex channel
	input  logic                                vtx_valid,
	output logic                                vtx_stall,
	input  logic signed [ttuv_pkg::POS_W-1:0]   pos_x,
	input  logic signed [ttuv_pkg::POS_W-1:0]   pos_y,
	input  logic signed [ttuv_pkg::POS_W-1:0]   pos_z,
	input  logic signed [ttuv_pkg::TEX_W-1:0]   tex_u,
	input  logic signed [ttuv_pkg::TEX_W-1:0]   tex_v,
	// tangent channel
	output logic                                tan_valid,
	input  logic                                tan_stall,
	output logic signed [ttuv_pkg::QUO_W-1:0]   tangent_x,
	output logic signed [ttuv_pkg::QUO_W-1:0]   tangent_y,
	output logic signed [ttuv_pkg::QUO_W-1:0]   tangent_z,
	output logic                                singular,
	output logic                                clipped
);
	import ttuv_pkg::*;

	// Sequencer codes
	localparam logic [2:0] S_IDLE   = 3'd0;  // taking vertices
	localparam logic [2:0] S_PREP   = 3'd1;  // deltas and edges
	localparam logic [2:0] S_MUL    = 3'd2;  // multiplier issue
	localparam logic [2:0] S_ACC    = 3'd3;  // accumulate product
	localparam logic [2:0] S_DCHK   = 3'd4;  // determinant zero test
	localparam logic [2:0] S_DSTART = 3'd5;  // launch division
	localparam logic [2:0] S_DIV    = 3'd6;  // wait for quotient
	localparam logic [2:0] S_OUT    = 3'd7;  // load output register

	localparam logic [1:0] SLOT_LAST = 2'd2;
	localparam logic [2:0] OP_DET    = 3'd1;  // second product of det
	localparam logic [2:0] OP_LAST   = 3'd7;  // second product of z numerator

	// ---------------- control state ----------------
	logic [2:0] state_q;
	logic [1:0] slot_q;
	logic [2:0] op_q;
	logic       tan_valid_q;

	// ---------------- held vertices and working registers ----------------
	logic [POS_W-1:0]        hp_q [0:5];   // x,y,z of vertex 0 then vertex 1
	logic [TEX_W-1:0]        ht_q [0:3];   // u,v of vertex 0 then vertex 1
	logic [POS_W-1:0]        p2_q [0:2];
	logic [TEX_W-1:0]        u2_q, v2_q;
	logic signed [DU_W-1:0]  du0_q, dv0_q, du1_q, dv1_q;
	logic signed [E_W-1:0]   e0_q [0:2];
	logic signed [E_W-1:0]   e1_q [0:2];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DET_W-1:0] det_q;
	logic [QUO_W-1:0]        tan_q [0:2];
	logic                    sing_q;
	logic                    clip_q;
	logic [QUO_W-1:0]        out_x_q, out_y_q, out_z_q;
	logic                    out_sing_q, out_clip_q;

	logic                    vtx_xfer;
	logic                    last_xfer;
	logic                    out_load;
	logic                    out_zero;
	logic                    mul_en;
	logic                    div_start;
	logic signed [DU_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [ACC_W-1:0] prod_q;
	ttuv_div_stat_t          div_stat;
	logic signed [DU_W-1:0]  du0_w, dv0_w, du1_w, dv1_w;
	logic                    uv_flat;

	assign vtx_stall = (state_q != S_IDLE);
	assign vtx_xfer  = vtx_valid && !vtx_stall;
	assign last_xfer = vtx_xfer && (slot_q == SLOT_LAST);
	assign out_load  = (state_q == S_OUT) && (!tan_valid_q || !tan_stall);
	assign mul_en    = (state_q == S_MUL);
	assign div_start = (state_q == S_DSTART);

	// uv deltas against vertex 0; a flat uv map falls back to the identity
	assign du0_w   = {ht_q[2][TEX_W-1], ht_q[2]} - {ht_q[0][TEX_W-1], ht_q[0]};
	assign dv0_w   = {ht_q[3][TEX_W-1], ht_q[3]} - {ht_q[1][TEX_W-1], ht_q[1]};
	assign du1_w   = {u2_q[TEX_W-1], u2_q} - {ht_q[0][TEX_W-1], ht_q[0]};
	assign dv1_w   = {v2_q[TEX_W-1], v2_q} - {ht_q[1][TEX_W-1], ht_q[1]};
	assign uv_flat = (du0_w == '0) && (dv0_w == '0) && (du1_w == '0) && (dv1_w == '0);

	// Operand schedule: det = du0*dv1 - dv0*du1, then per axis dv1*e0 - dv0*e1
	always_comb begin
		mul_a = op_q[0] ? dv0_q : dv1_q;
		unique case (op_q)
			3'd0: mul_b = {{(MB_W-DU_W){du0_q[DU_W-1]}}, du0_q};
			3'd1: mul_b = {{(MB_W-DU_W){du1_q[DU_W-1]}}, du1_q};
			3'd2: mul_b = {e0_q[0][E_W-1], e0_q[0]};
			3'd3: mul_b = {e1_q[0][E_W-1], e1_q[0]};
			3'd4: mul_b = {e0_q[1][E_W-1], e0_q[1]};
			3'd5: mul_b = {e1_q[1][E_W-1], e1_q[1]};
			3'd6: mul_b = {e0_q[2][E_W-1], e0_q[2]};
			3'd7: mul_b = {e1_q[2][E_W-1], e1_q[2]};
		endcase
	end

	ttuv_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	ttuv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.det    (det_q),
		.stat   (div_stat)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			op_q        <= '0;
			tan_valid_q <= 1'b0;
		end else begin
			// output register: set on load, cleared by the downstream transfer
			if (out_load) begin
				tan_valid_q <= 1'b1;
			end else if (!tan_stall) begin
				tan_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (vtx_xfer) begin
						if (slot_q == SLOT_LAST) begin
							slot_q  <= '0;
							state_q <= S_PREP;
						end else if (slot_q == 2'd1) begin
							slot_q <= SLOT_LAST;
						end else begin
							// unused slot code behaves as slot 0
							slot_q <= 2'd1;
						end
					end
				end
				S_PREP: begin
					op_q    <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (!op_q[0]) begin
						op_q    <= op_q + 1'b1;
						state_q <= S_MUL;
					end else if (op_q == OP_DET) begin
						state_q <= S_DCHK;
					end else begin
						state_q <= S_DSTART;
					end
				end
				S_DCHK: begin
					if (acc_q == '0) begin
						state_q <= S_OUT;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_DSTART: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (op_q == OP_LAST) begin
							state_q <= S_OUT;
						end else begin
							op_q    <= op_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (vtx_xfer) begin
			if (slot_q == SLOT_LAST) begin
				p2_q[0] <= pos_x;
				p2_q[1] <= pos_y;
				p2_q[2] <= pos_z;
				u2_q    <= tex_u;
				v2_q    <= tex_v;
			end else if (slot_q == 2'd1) begin
				hp_q[3] <= pos_x;
				hp_q[4] <= pos_y;
				hp_q[5] <= pos_z;
				ht_q[2] <= tex_u;
				ht_q[3] <= tex_v;
			end else begin
				hp_q[0] <= pos_x;
				hp_q[1] <= pos_y;
				hp_q[2] <= pos_z;
				ht_q[0] <= tex_u;
				ht_q[1] <= tex_v;
			end
		end

		if (state_q == S_PREP) begin
			du0_q  <= uv_flat ? UV_ONE : du0_w;
			dv0_q  <= dv0_w;
			du1_q  <= du1_w;
			dv1_q  <= uv_flat ? UV_ONE : dv1_w;
			sing_q <= 1'b0;
			clip_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				e0_q[k] <= {hp_q[3+k][POS_W-1], hp_q[3+k]} - {hp_q[k][POS_W-1], hp_q[k]};
				e1_q[k] <= {p2_q[k][POS_W-1], p2_q[k]} - {hp_q[k][POS_W-1], hp_q[k]};
			end
		end

		if (state_q == S_ACC) begin
			acc_q <= op_q[0] ? (acc_q - prod_q) : prod_q;
		end

		if (state_q == S_DCHK) begin
			det_q  <= $signed(acc_q[DET_W-1:0]);
			sing_q <= (acc_q == '0);
		end

		// quotients arrive x, y, z: shift them in
		if (state_q == S_DIV && div_stat.done) begin
			tan_q[0] <= tan_q[1];
			tan_q[1] <= tan_q[2];
			tan_q[2] <= div_stat.quo;
			clip_q   <= clip_q | div_stat.clip;
		end

		if (out_load) begin
			out_x_q    <= sing_q ? '0 : tan_q[0];
			out_y_q    <= sing_q ? '0 : tan_q[1];
			out_z_q    <= sing_q ? '0 : tan_q[2];
			out_sing_q <= sing_q;
			out_clip_q <= sing_q ? 1'b0 : clip_q;
		end
	end

	assign tan_valid = tan_valid_q;
	assign tangent_x = $signed(out_x_q);
	assign tangent_y = $signed(out_y_q);
	assign tangent_z = $signed(out_z_q);
	assign singular  = out_sing_q;
	assign clipped   = out_clip_q;

	// ---------------- checks ----------------
	assign out_zero = (out_x_q == '0) && (out_y_q == '0) && (out_z_q == '0) && !clipped;

	`ASSERT_IMPLIES(a_slot_range, clk, arst_n, 1'b1, slot_q != 2'd3)
	`ASSERT_IMPLIES(a_done_in_div, clk, arst_n, div_stat.done, state_q == S_DIV)
	`ASSERT_NEXT(a_third_vtx_starts, clk, arst_n, last_xfer, state_q == S_PREP)
	`ASSERT_IMPLIES(a_singular_zero, clk, arst_n, tan_valid && singular, out_zero)

endmodule

>>> sv/ttuv_mul.sv
// Shared signed multiplier with registered product.
module ttuv_mul (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic signed [ttuv_pkg::DU_W-1:0]        a,
	input  logic signed [ttuv_pkg::MB_W-1:0]        b,
	output logic signed [ttuv_pkg::ACC_W-1:0]       p_q
);
	import ttuv_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

>>> sv/ttuv_div.sv
// Radix-4 restoring divider with sign fix-up and 32-bit saturation.
module ttuv_div (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [ttuv_pkg::ACC_W-1:0]       num,
	input  logic signed [ttuv_pkg::DET_W-1:0]       det,
	output ttuv_pkg::ttuv_div_stat_t                stat
);
	import ttuv_pkg::*;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_INIT = 2'd1;
	localparam logic [1:0] D_RUN  = 2'd2;
	localparam logic [1:0] D_FIN  = 2'd3;
	localparam int CNT_W = $clog2(DIG_N);

	logic [1:0]         phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic               ovf_q;
	logic [ACC_W-1:0]   magn_q;
	logic [DET_W-1:0]   d_q;
	logic [DET_W+1:0]   d3_q;
	logic [DET_W-1:0]   rem_q;
	logic [QUO_W-1:0]   lo_q;
	logic [QUO_W-1:0]   quo_q;

	logic [DET_W-1:0]   hi_ext;
	logic [DET_W+1:0]   r4, d1, d2, r_d1, r_d2, r_d3;
	logic [1:0]         digit;
	logic [DET_W+1:0]   r_next;

	assign hi_ext = {{(DET_W-HI_W){1'b0}}, magn_q[ACC_W-1:LO_W]};
	assign r4     = {rem_q, lo_q[QUO_W-1 -: 2]};
	assign d1     = {2'b00, d_q};
	assign d2     = {1'b0, d_q, 1'b0};
	assign r_d1   = r4 - d1;
	assign r_d2   = r4 - d2;
	assign r_d3   = r4 - d3_q;

	// one quotient digit per step
	always_comb begin
		priority if (r4 >= d3_q) begin
			digit  = 2'd3;
			r_next = r_d3;
		end else if (r4 >= d2) begin
			digit  = 2'd2;
			r_next = r_d2;
		end else if (r4 >= d1) begin
			digit  = 2'd1;
			r_next = r_d1;
		end else begin
			digit  = 2'd0;
			r_next = r4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (phase_q)
				D_IDLE: begin
					if (start) begin
						phase_q <= D_INIT;
					end
				end
				D_INIT: begin
					phase_q <= D_RUN;
					cnt_q   <= '0;
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIG_N - 1)) begin
						phase_q <= D_FIN;
					end
				end
				D_FIN: begin
					phase_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == D_IDLE && start) begin
			magn_q <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
			d_q    <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
			neg_q  <= num[ACC_W-1] ^ det[DET_W-1];
		end
		if (phase_q == D_INIT) begin
			// quotient of 2^32 or more shows in the top part alone
			ovf_q <= hi_ext >= d_q;
			rem_q <= hi_ext;
			d3_q  <= {2'b00, d_q} + {1'b0, d_q, 1'b0};
			lo_q  <= {magn_q[LO_W-1:0], {SCALE_SH{1'b0}}};
			quo_q <= '0;
		end
		if (phase_q == D_RUN) begin
			rem_q <= r_next[DET_W-1:0];
			lo_q  <= {lo_q[QUO_W-3:0], 2'b00};
			quo_q <= {quo_q[QUO_W-3:0], digit};
		end
	end

	always_comb begin
		stat.done = (phase_q == D_FIN);
		if (ovf_q) begin
			stat.clip = 1'b1;
			stat.quo  = neg_q ? SAT_MIN : SAT_MAX;
		end else if (neg_q) begin
			stat.clip = quo_q > SAT_MIN;
			stat.quo  = stat.clip ? SAT_MIN : QUO_W'(-quo_q);
		end else begin
			stat.clip = quo_q[QUO_W-1];
			stat.quo  = stat.clip ? SAT_MAX : quo_q;
		end
	end

endmodule

>>> tb/sv/triangle_tangent_from_uv_unit_test.sv
// Self-checking bench for the tangent-from-uv unit: directed triangles, then random ones.
module triangle_tangent_from_uv_unit_test;

	import ttuv_pkg::*;

	// one vertex as offered on the input channel
	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic signed [TEX_W-1:0] u;
		logic signed [TEX_W-1:0] v;
	} vertex_t;

	// one result as seen on the output channel
	typedef struct packed {
		logic signed [QUO_W-1:0] x;
		logic signed [QUO_W-1:0] y;
		logic signed [QUO_W-1:0] z;
		logic                    singular;
		logic                    clipped;
	} tangent_t;

	// directed row: a vertex and, on some third vertices, the result typed in by hand
	typedef struct packed {
		vertex_t  vtx;
		logic     typed;
		tangent_t res;
	} stim_row_t;

	localparam tangent_t NO_RES = '0;

	localparam stim_row_t DIRECTED [24] = '{
		// all texcoords equal: unit uv, tangent is the first edge
		'{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h1234, 16'h0567}, 1'b0, NO_RES},
		'{'{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 16'h1234, 16'h0567}, 1'b0, NO_RES},
		'{'{32'h7FFF_0000, 32'hFF00_0000, 32'h0000_0001, 16'h1234, 16'h0567}, 1'b1,
			'{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0, 1'b0}},
		// collinear uv: zero determinant
		'{'{32'h0001_2345, 32'hFFFF_0000, 32'h0050_0000, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		'{'{32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 16'h1000, 16'h1000}, 1'b0, NO_RES},
		'{'{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h2000, 16'h2000}, 1'b1,
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}},
		// widest edges under unit uv: clamp high and low
		'{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005, 16'h8000, 16'h7FFF}, 1'b0, NO_RES},
		'{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005, 16'h8000, 16'h7FFF}, 1'b0, NO_RES},
		'{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h8000, 16'h7FFF}, 1'b1,
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1}},
		// edges landing exactly on the range ends: no clamp
		'{'{32'h0000_0000, 32'h4000_0000, 32'h8000_0000, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		'{'{32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		'{'{32'h0000_1111, 32'h0000_2222, 32'h0000_3333, 16'h0000, 16'h0000}, 1'b1,
			'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}},
		// first two deltas zero, third not: no substitution, singular
		'{'{32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 16'd100, 16'd200}, 1'b0, NO_RES},
		'{'{32'hFFFF_F000, 32'h0000_0000, 32'h0000_8000, 16'd100, 16'd200}, 1'b0, NO_RES},
		'{'{32'h1000_0000, 32'h2000_0000, 32'h3000_0000, 16'd300, 16'd200}, 1'b1,
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}},
		// extreme texcoords and positions
		'{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000}, 1'b0, NO_RES},
		'{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'h8000, 16'h7FFF}, 1'b0, NO_RES},
		'{'{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 16'h8000, 16'h8000}, 1'b0, NO_RES},
		// plain unit square mapping
		'{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		'{'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 16'h1000, 16'h0000}, 1'b0, NO_RES},
		'{'{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 16'h0000, 16'h1000}, 1'b0, NO_RES},
		// smallest determinant with long edges
		'{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		'{'{32'h0010_0000, 32'h0000_0100, 32'hFFF0_0000, 16'h0001, 16'h0000}, 1'b0, NO_RES},
		'{'{32'h0000_0010, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'h0001}, 1'b0, NO_RES}
	};

	localparam int RANDOM_TRIANGLES = 160;
	localparam int LONG_HOLD        = 400;   // receiver hold-off to back the unit up
	localparam int HOLD_AT          = 25;    // after this many result transfers
	localparam int DRAIN_CYCLES     = 100;   // settle time after the last owed result

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    vtx_valid = 1'b0;
	logic                    vtx_stall;
	logic signed [POS_W-1:0] pos_x     = '0;
	logic signed [POS_W-1:0] pos_y     = '0;
	logic signed [POS_W-1:0] pos_z     = '0;
	logic signed [TEX_W-1:0] tex_u     = '0;
	logic signed [TEX_W-1:0] tex_v     = '0;
	logic                    tan_valid;
	logic                    tan_stall = 1'b0;
	logic signed [QUO_W-1:0] tangent_x;
	logic signed [QUO_W-1:0] tangent_y;
	logic signed [QUO_W-1:0] tangent_z;
	logic                    singular;
	logic                    clipped;

	// predictor state: vertices 0 and 1 of the triangle being gathered
	vertex_t     held_vtx [2];
	logic [1:0]  fill_slot = 2'd0;
	tangent_t    tangent_due [$];   // results still owed by the unit, oldest first
	int          fail_count = 0;

	triangle_tangent_from_uv_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.tex_u     (tex_u),
		.tex_v     (tex_v),
		.tan_valid (tan_valid),
		.tan_stall (tan_stall),
		.tangent_x (tangent_x),
		.tangent_y (tangent_y),
		.tangent_z (tangent_z),
		.singular  (singular),
		.clipped   (clipped)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Exact tangent of one triangle: (dv1*e0 - dv0*e1) * 2^12 / det, cut toward zero
	// and clamped. Magnitudes stay below 2^63, so plain 64-bit division is exact.
	function automatic tangent_t tangent_from(vertex_t a, vertex_t b, vertex_t c);
		longint            pa [3];
		longint            pb [3];
		longint            pc [3];
		longint            du0, dv0, du1, dv1, det, num;
		logic [63:0]       nmag, dmag, q;
		logic [QUO_W-1:0]  comp [3];
		tangent_t          r;
		pa = '{longint'(a.px), longint'(a.py), longint'(a.pz)};
		pb = '{longint'(b.px), longint'(b.py), longint'(b.pz)};
		pc = '{longint'(c.px), longint'(c.py), longint'(c.pz)};
		du0 = longint'(b.u) - longint'(a.u);
		dv0 = longint'(b.v) - longint'(a.v);
		du1 = longint'(c.u) - longint'(a.u);
		dv1 = longint'(c.v) - longint'(a.v);
		// flat texcoords: fall back to unit uv so the tangent follows the first edge
		if (du0 == 0 && dv0 == 0 && du1 == 0 && dv1 == 0) begin
			du0 = longint'(UV_ONE);
			dv1 = longint'(UV_ONE);
		end
		det = du0 * dv1 - dv0 * du1;
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		dmag = det < 0 ? -det : det;
		for (int k = 0; k < 3; k++) begin
			num  = dv1 * (pb[k] - pa[k]) - dv0 * (pc[k] - pa[k]);
			nmag = num < 0 ? -num : num;
			nmag = nmag << SCALE_SH;
			q    = nmag / dmag;
			if ((num < 0) != (det < 0)) begin
				if (q > 64'h8000_0000) begin
					comp[k]   = SAT_MIN;
					r.clipped = 1'b1;
				end else begin
					comp[k] = -q[QUO_W-1:0];
				end
			end else if (q > 64'h7FFF_FFFF) begin
				comp[k]   = SAT_MAX;
				r.clipped = 1'b1;
			end else begin
				comp[k] = q[QUO_W-1:0];
			end
		end
		r.x = comp[0];
		r.y = comp[1];
		r.z = comp[2];
		return r;
	endfunction

	function automatic int signed_draw(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// position component: full range, small, or one of the range ends, -1 or 0
	function automatic logic [POS_W-1:0] position_draw();
		case ($urandom_range(0, 3))
			0: return POS_W'(signed_draw(1 << 20));
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0000;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Offer one vertex after a gap, hold it until the transfer, then fold it into the
	// predictor. Valid stays high across back-to-back transfers (one assignment per edge).
	task automatic offer_vertex(vertex_t vin, int gap, logic typed, tangent_t typed_res);
		tangent_t due_res;
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_valid <= 1'b1;
		pos_x     <= vin.px;
		pos_y     <= vin.py;
		pos_z     <= vin.pz;
		tex_u     <= vin.u;
		tex_v     <= vin.v;
		do @(posedge clk); while (vtx_stall);
		if (fill_slot == 2'd2) begin
			due_res     = typed ? typed_res : tangent_from(held_vtx[0], held_vtx[1], vin);
			tangent_due = {tangent_due, due_res};
			fill_slot   = 2'd0;
		end else begin
			held_vtx[fill_slot[0]] = vin;
			fill_slot = fill_slot + 2'd1;
		end
	endtask

	task automatic check_field(string name, logic [QUO_W-1:0] want, logic [QUO_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// result side: compare every transfer with the oldest owed tangent
	always @(posedge clk) begin : tangent_check
		tangent_t want;
		if (arst_n && tan_valid && !tan_stall) begin
			if (tangent_due.size() == 0) begin
				$display("%0t: tangent expected none, got %h %h %h s=%b c=%b", $time,
					tangent_x, tangent_y, tangent_z, singular, clipped);
				fail_count++;
			end else begin
				want = tangent_due.pop_front();
				check_field("tangent_x", want.x, tangent_x);
				check_field("tangent_y", want.y, tangent_y);
				check_field("tangent_z", want.z, tangent_z);
				check_field("singular", QUO_W'(want.singular), QUO_W'(singular));
				check_field("clipped", QUO_W'(want.clipped), QUO_W'(clipped));
			end
		end
	end

	// Receiver: random stall before each transfer, calm stretches, and one long
	// hold-off so the unit fills and pushes back on the vertex side.
	initial begin : tangent_sink
		int wait_cycles;
		int taken;
		taken = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (taken == HOLD_AT)
				wait_cycles = LONG_HOLD;
			else if ((taken / 32) % 3 == 2)
				wait_cycles = 0;
			else
				wait_cycles = $urandom_range(0, 16);
			if (wait_cycles > 0) begin
				tan_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				tan_stall <= 1'b0;
			end
			do @(posedge clk); while (!tan_valid);
			taken++;
		end
	end

	// Sender: reset, directed table, random triangles, drain, verdict.
	initial begin : vertex_source
		int        gap;
		int        item_no;
		int        kind;
		int        m;
		int        du, dv;
		vertex_t   tri_vtx [3];
		item_no = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			gap = (i < 12) ? 0 : $urandom_range(0, 16);
			offer_vertex(DIRECTED[i].vtx, gap, DIRECTED[i].typed, DIRECTED[i].res);
			item_no++;
		end

		repeat (RANDOM_TRIANGLES) begin
			for (int k = 0; k < 3; k++) begin
				tri_vtx[k].px = position_draw();
				tri_vtx[k].py = position_draw();
				tri_vtx[k].pz = position_draw();
			end
			kind = $urandom_range(0, 9);
			case (kind)
				// flat texcoords: unit-uv fallback
				4: begin
					tri_vtx[0].u = TEX_W'($urandom_range(0, 65535));
					tri_vtx[0].v = TEX_W'($urandom_range(0, 65535));
					tri_vtx[1].u = tri_vtx[0].u;
					tri_vtx[1].v = tri_vtx[0].v;
					tri_vtx[2].u = tri_vtx[0].u;
					tri_vtx[2].v = tri_vtx[0].v;
				end
				// collinear uv: zero determinant, kept clear of 16-bit wrap
				5: begin
					du = signed_draw(4000);
					dv = signed_draw(4000);
					m  = signed_draw(3);
					tri_vtx[0].u = TEX_W'(signed_draw(4000));
					tri_vtx[0].v = TEX_W'(signed_draw(4000));
					tri_vtx[1].u = tri_vtx[0].u + TEX_W'(du);
					tri_vtx[1].v = tri_vtx[0].v + TEX_W'(dv);
					tri_vtx[2].u = tri_vtx[0].u + TEX_W'(m * du);
					tri_vtx[2].v = tri_vtx[0].v + TEX_W'(m * dv);
				end
				// tiny deltas: small determinant, clamping likely
				6: begin
					tri_vtx[0].u = TEX_W'(signed_draw(30000));
					tri_vtx[0].v = TEX_W'(signed_draw(30000));
					for (int k = 1; k < 3; k++) begin
						tri_vtx[k].u = tri_vtx[0].u + TEX_W'(signed_draw(2));
						tri_vtx[k].v = tri_vtx[0].v + TEX_W'(signed_draw(2));
					end
				end
				// moderate texcoords
				7, 8, 9: begin
					for (int k = 0; k < 3; k++) begin
						tri_vtx[k].u = TEX_W'(signed_draw(8192));
						tri_vtx[k].v = TEX_W'(signed_draw(8192));
					end
				end
				// full-range texcoords
				default: begin
					for (int k = 0; k < 3; k++) begin
						tri_vtx[k].u = TEX_W'($urandom_range(0, 65535));
						tri_vtx[k].v = TEX_W'($urandom_range(0, 65535));
					end
				end
			endcase
			for (int k = 0; k < 3; k++) begin
				gap = ((item_no / 48) % 4 == 3) ? 0 : $urandom_range(0, 16);
				offer_vertex(tri_vtx[k], gap, 1'b0, NO_RES);
				item_no++;
			end
		end
		vtx_valid <= 1'b0;

		while (tangent_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin : run_limit
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule
